>>> rtl/iir_direct_form_filter_core_macros.svh
// Assertion macros for the IIR direct-form filter core.
// Define ASSERT_OFF to compile the checks out; no other dependencies.
`ifndef IIR_DIRECT_FORM_FILTER_CORE_MACROS_SVH
`define IIR_DIRECT_FORM_FILTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define IIRDF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset
`define IIRDF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define IIRDF_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define IIRDF_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> rtl/iirdf_pkg.sv
// Shared types and constants for the IIR direct-form filter core.
// No dependencies; imported by the MAC unit and the top level.
package iirdf_pkg;

   // Filter order (1 to 3) and the fixed storage behind it
   localparam int IIRDF_ORDER  = 3;
   localparam int IIRDF_HIST   = 3;
   localparam int IIRDF_TAPS   = 2 * IIRDF_ORDER + 1;
   localparam int IIRDF_STEP_W = (IIRDF_TAPS > 1) ? $clog2(IIRDF_TAPS) : 1;

   // Datapath widths
   localparam int COEF_W = 24;
   localparam int SAMP_W = 16;
   localparam int PROD_W = COEF_W + SAMP_W;
   localparam int ACC_W  = PROD_W + 4;
   localparam int FRAC_W = 20;
   localparam int CSR_IDX_W = 3;

   // Rounding bias: one half in Q24.20
   localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_W - 1);

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COEF_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COEF_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COEF_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COEF_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_COEF_1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_COEF_2 = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_COEF_3 = 3'd6;

   // Input operation codes
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_FLUSH  = 1'b1;

   // Reset value of the leading numerator coefficient (1.0)
   localparam logic signed [COEF_W-1:0] NUM0_RESET = 24'sd1048576;

   // Control from the sequencer to the shared MAC unit
   typedef struct packed {
      logic clear;    // load the accumulator with the rounding bias
      logic mul_en;   // start a product this cycle
      logic sub;      // subtract that product when it lands
   } mac_ctrl_type;

endpackage

>>> rtl/iirdf_mac.sv
// Shared multiply-accumulate unit: registered 24x16 product, then add or subtract.
// Depends on iirdf_pkg.
module iirdf_mac import iirdf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctrl_type             ctrl,
   input  logic signed [COEF_W-1:0] coef,
   input  logic signed [SAMP_W-1:0] samp,
   output logic signed [ACC_W-1:0]  acc
);

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     prod_vld_ff;
   logic                     prod_sub_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_ext;

   // Multiply stage
   assign prod_in = coef * samp;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.mul_en;
      end
      if (ctrl.mul_en) begin
         prod_ff     <= prod_in;
         prod_sub_ff <= ctrl.sub;
      end
   end

   // Accumulate stage
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = ROUND_BIAS;
      end else if (prod_vld_ff) begin
         acc_in = prod_sub_ff ? (acc_ff - prod_ext) : (acc_ff + prod_ext);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> rtl/iir_direct_form_filter_core.sv
// Top level of the IIR direct-form-I filter core: sequencer, histories, output.
// Depends on iirdf_pkg, iirdf_mac and iir_direct_form_filter_core_macros.svh.
//
// Usage:
//   req channel: one item per transfer, req_operation selects filtering of
//   req_sample_in or a flush of both histories. rsp channel: one result per
//   item, rsp_filtered_out with rsp_saturated set when the sum was clipped.
//   csr channel: writes a Q4.20 coefficient by index (0..3 numerator,
//   4..6 feedback); always ready, indexes above 6 are dropped. Write only
//   while no item is in flight.
// Timing:
//   A filter item walks 2*ORDER+1 products through one shared multiplier and
//   accumulator, one product per cycle, then state DRAIN for the last
//   accumulate and state DONE to round and register the result. A flush goes
//   straight to DONE. req_ready is low while an item is worked on, so a new
//   item is taken only after the last one has written its result.
//   If the receiver stalls, the finished result holds in the output register;
//   a next item can be taken meanwhile but waits before it writes its result.
// Reset:
//   Clears both histories, restores the coefficient defaults (pass-through)
//   and empties the output register.
`include "iir_direct_form_filter_core_macros.svh"

module iir_direct_form_filter_core import iirdf_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // input item channel
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_operation,
   input  logic signed [SAMP_W-1:0] req_sample_in,
   // result channel
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SAMP_W-1:0] rsp_filtered_out,
   output logic                     rsp_saturated,
   // configuration write channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [COEF_W-1:0]        csr_data
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_MAC   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   localparam int Y_W = ACC_W - FRAC_W;
   localparam logic signed [Y_W-1:0] Y_MAX = Y_W'(32767);
   localparam logic signed [Y_W-1:0] Y_MIN = -Y_W'(32768);

   logic [1:0]               state_ff, state_in;
   logic [IIRDF_STEP_W-1:0]  step_ff, step_in;
   logic                     flush_ff, flush_in;
   logic signed [SAMP_W-1:0] sample_ff;

   logic signed [COEF_W-1:0] num_coef_ff [0:IIRDF_HIST];
   logic signed [COEF_W-1:0] den_coef_ff [1:IIRDF_HIST];
   logic signed [SAMP_W-1:0] xh_ff [0:IIRDF_HIST-1];
   logic signed [SAMP_W-1:0] yh_ff [0:IIRDF_HIST-1];

   logic                     rsp_valid_ff;
   logic signed [SAMP_W-1:0] rsp_out_ff;
   logic                     rsp_sat_ff;

   logic                     req_xfer;
   logic                     rsp_xfer;
   logic                     load_rsp;
   mac_ctrl_type             mac_ctrl;
   logic signed [COEF_W-1:0] op_coef;
   logic signed [SAMP_W-1:0] op_samp;
   logic                     op_sub;
   logic signed [ACC_W-1:0]  acc;
   logic signed [Y_W-1:0]    y_wide;
   logic signed [SAMP_W-1:0] y_sat;
   logic                     y_clip;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid & req_ready;
   assign rsp_xfer  = rsp_valid_ff & rsp_ready;
   assign load_rsp  = (state_ff == ST_DONE) & (~rsp_valid_ff | rsp_ready);
   assign csr_ready = 1'b1;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      flush_in = flush_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               flush_in = (req_operation == OP_FLUSH);
               step_in  = '0;
               state_in = (req_operation == OP_FLUSH) ? ST_DONE : ST_MAC;
            end
         end
         ST_MAC: begin
            if (step_ff == IIRDF_STEP_W'(IIRDF_TAPS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         flush_ff <= flush_in;
      end
      if (req_xfer) begin
         sample_ff <= req_sample_in;
      end
   end

   // Select the operands of the current step
   always_comb begin
      op_coef = num_coef_ff[0];
      op_samp = sample_ff;
      op_sub  = 1'b0;
      for (int i = 1; i <= IIRDF_ORDER; i++) begin
         if (step_ff == IIRDF_STEP_W'(i)) begin
            op_coef = num_coef_ff[i];
            op_samp = xh_ff[i-1];
         end
         if (step_ff == IIRDF_STEP_W'(IIRDF_ORDER + i)) begin
            op_coef = den_coef_ff[i];
            op_samp = yh_ff[i-1];
            op_sub  = 1'b1;
         end
      end
   end

   assign mac_ctrl.clear  = req_xfer;
   assign mac_ctrl.mul_en = (state_ff == ST_MAC);
   assign mac_ctrl.sub    = op_sub;

   iirdf_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .coef  (op_coef),
      .samp  (op_samp),
      .acc   (acc)
   );

   // Round (bias already in the accumulator) and saturate
   assign y_wide = acc[ACC_W-1:FRAC_W];

   always_comb begin
      y_clip = 1'b0;
      y_sat  = y_wide[SAMP_W-1:0];
      if (y_wide > Y_MAX) begin
         y_clip = 1'b1;
         y_sat  = Y_MAX[SAMP_W-1:0];
      end else if (y_wide < Y_MIN) begin
         y_clip = 1'b1;
         y_sat  = Y_MIN[SAMP_W-1:0];
      end
   end

   // Coefficient writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_coef_ff[0] <= NUM0_RESET;
         for (int i = 1; i <= IIRDF_HIST; i++) begin
            num_coef_ff[i] <= '0;
            den_coef_ff[i] <= '0;
         end
      end else if (csr_valid & csr_ready) begin
         case (csr_index)
            CSR_NUM_COEF_0: num_coef_ff[0] <= signed'(csr_data);
            CSR_NUM_COEF_1: num_coef_ff[1] <= signed'(csr_data);
            CSR_NUM_COEF_2: num_coef_ff[2] <= signed'(csr_data);
            CSR_NUM_COEF_3: num_coef_ff[3] <= signed'(csr_data);
            CSR_DEN_COEF_1: den_coef_ff[1] <= signed'(csr_data);
            CSR_DEN_COEF_2: den_coef_ff[2] <= signed'(csr_data);
            CSR_DEN_COEF_3: den_coef_ff[3] <= signed'(csr_data);
            default: ;
         endcase
      end
   end

   // Shift or clear the histories when the result is written
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < IIRDF_HIST; i++) begin
            xh_ff[i] <= '0;
            yh_ff[i] <= '0;
         end
      end else if (load_rsp) begin
         if (flush_ff) begin
            for (int i = 0; i < IIRDF_HIST; i++) begin
               xh_ff[i] <= '0;
               yh_ff[i] <= '0;
            end
         end else begin
            for (int i = IIRDF_HIST - 1; i > 0; i--) begin
               xh_ff[i] <= xh_ff[i-1];
               yh_ff[i] <= yh_ff[i-1];
            end
            xh_ff[0] <= sample_ff;
            yh_ff[0] <= y_sat;
         end
      end
   end

   // Output register: hold until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load_rsp) begin
         rsp_out_ff <= flush_ff ? '0 : y_sat;
         rsp_sat_ff <= flush_ff ? 1'b0 : y_clip;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_out = rsp_out_ff;
   assign rsp_saturated    = rsp_sat_ff;

   // Checks
   `IIRDF_ASSERT_NXT(a_busy_after_req, clock, reset, req_xfer, !req_ready)
   `IIRDF_ASSERT_NXT(a_flush_zero, clock, reset, load_rsp && flush_ff, rsp_valid && (rsp_filtered_out == '0) && !rsp_saturated)
   `IIRDF_ASSERT_IMP(a_sat_at_rail, clock, reset, rsp_valid && rsp_saturated, (rsp_filtered_out == 16'sh7fff) || (rsp_filtered_out == 16'sh8000))
   `IIRDF_ASSERT_IMP(a_mac_in_seq, clock, reset, mac_ctrl.mul_en, !req_ready && !load_rsp)

endmodule

>>> bench/tb.sv
// Self-checking bench for iir_direct_form_filter_core: coefficient loads, filtering and flushes.
// Depends on iirdf_pkg and the core RTL; the expected outputs come from an in-bench filter model.
`timescale 1ns / 100ps

module tb;
   import iirdf_pkg::*;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 12;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SEGMENT_ITEMS  = 50;
   localparam int MAX_PRINTED    = 40;
   localparam int NUM_REGS       = 7;

   // Index past the last register, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   localparam logic signed [SAMP_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMP_W-1:0] SAMPLE_MIN = -16'sh8000;
   localparam logic signed [COEF_W-1:0] COEF_MAX   = 24'sh7FFFFF;
   localparam logic signed [COEF_W-1:0] COEF_MIN   = -24'sh800000;
   localparam logic signed [COEF_W-1:0] COEF_HALF  = 24'sd524288;

   // Third-order low-pass, numerator already scaled by the gain
   localparam logic signed [COEF_W-1:0] BW_B0 = 24'sd18969;
   localparam logic signed [COEF_W-1:0] BW_B1 = 24'sd56917;
   localparam logic signed [COEF_W-1:0] BW_A1 = -24'sd1845535;
   localparam logic signed [COEF_W-1:0] BW_A2 = 24'sd1240350;
   localparam logic signed [COEF_W-1:0] BW_A3 = -24'sd291566;

   typedef struct packed {
      logic signed [SAMP_W-1:0] filtered;
      logic                     saturated;
   } filter_result_type;

   // DUT ports; every input is known from time zero
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_operation = OP_FILTER;
   logic signed [SAMP_W-1:0] req_sample_in = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [SAMP_W-1:0] rsp_filtered_out;
   logic                     rsp_saturated;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [COEF_W-1:0]        csr_data = '0;

   // Filter model state
   logic signed [COEF_W-1:0] num_w [0:IIRDF_HIST];
   logic signed [COEF_W-1:0] den_w [1:IIRDF_HIST];
   logic signed [SAMP_W-1:0] x_hist [0:IIRDF_HIST-1];
   logic signed [SAMP_W-1:0] y_hist [0:IIRDF_HIST-1];

   logic signed [COEF_W-1:0] coef_plan [0:NUM_REGS-1];
   filter_result_type        expected_q [$];

   int error_count     = 0;
   int items_sent      = 0;
   int flushes_sent    = 0;
   int csr_writes      = 0;
   int results_checked = 0;
   int coef_sets       = 0;
   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int holdoff_len     = 0;
   int holdoff_count   = 0;
   int holdoff_seen    = 0;
   int hold_left       = 0;
   int idle_cycles     = 0;

   iir_direct_form_filter_core DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_filtered_out (rsp_filtered_out),
      .rsp_saturated    (rsp_saturated),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic void clear_histories();
      for (int i = 0; i < IIRDF_HIST; i++) begin
         x_hist[i] = '0;
         y_hist[i] = '0;
      end
   endfunction

   task automatic reset_model();
      num_w[0] = NUM0_RESET;
      for (int i = 1; i <= IIRDF_HIST; i++) begin
         num_w[i] = '0;
         den_w[i] = '0;
      end
      clear_histories();
   endtask

   task automatic apply_coef_write(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [COEF_W-1:0] data);
      if (idx <= CSR_NUM_COEF_3)
         num_w[idx] = data;
      else if (idx <= CSR_DEN_COEF_3)
         den_w[idx - CSR_DEN_COEF_1 + 1] = data;
   endtask

   // One item through the filter: exact sum, round half up, clip to 16 bits
   function automatic filter_result_type filter_step(input logic op,
                                                     input logic signed [SAMP_W-1:0] x);
      filter_result_type r;
      longint acc;
      longint y;
      r.filtered  = '0;
      r.saturated = 1'b0;
      if (op == OP_FLUSH) begin
         clear_histories();
         return r;
      end
      acc = longint'(num_w[0]) * longint'(x);
      for (int i = 1; i <= IIRDF_ORDER && i <= IIRDF_HIST; i++) begin
         acc += longint'(num_w[i]) * longint'(x_hist[i-1]);
         acc -= longint'(den_w[i]) * longint'(y_hist[i-1]);
      end
      acc += longint'(1) << (FRAC_W - 1);
      y = acc >>> FRAC_W;
      if (y > longint'(SAMPLE_MAX)) begin
         y = SAMPLE_MAX;
         r.saturated = 1'b1;
      end else if (y < longint'(SAMPLE_MIN)) begin
         y = SAMPLE_MIN;
         r.saturated = 1'b1;
      end
      r.filtered = y[SAMP_W-1:0];
      for (int i = IIRDF_HIST - 1; i > 0; i--) begin
         x_hist[i] = x_hist[i-1];
         y_hist[i] = y_hist[i-1];
      end
      x_hist[0] = x;
      y_hist[0] = r.filtered;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers

   // Offer one item; valid stays up afterwards so back-to-back transfers need no toggle
   task automatic send_item(input logic op, input logic signed [SAMP_W-1:0] sample);
      // Idle one cycle at a time, each with the sender's idle odds
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_sample_in <= sample;
      do @(posedge clock); while (!req_ready);
      expected_q.push_back(filter_step(op, sample));
      items_sent++;
      if (op == OP_FLUSH)
         flushes_sent++;
   endtask

   // Drop valid, wait for every outstanding result, then let the core settle
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_coef(input logic [CSR_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      apply_coef_write(idx, data);
      csr_writes++;
   endtask

   // Load all seven registers from coef_plan while the core is idle
   task automatic load_coef_plan();
      drain();
      for (int i = 0; i < NUM_REGS; i++)
         write_coef(CSR_IDX_W'(i), coef_plan[i]);
      csr_valid <= 1'b0;
      coef_sets++;
   endtask

   task automatic plan_uniform(input logic signed [COEF_W-1:0] c);
      for (int i = 0; i < NUM_REGS; i++)
         coef_plan[i] = c;
   endtask

   task automatic plan_passthrough();
      plan_uniform('0);
      coef_plan[CSR_NUM_COEF_0] = NUM0_RESET;
   endtask

   task automatic plan_lowpass();
      coef_plan[CSR_NUM_COEF_0] = BW_B0;
      coef_plan[CSR_NUM_COEF_1] = BW_B1;
      coef_plan[CSR_NUM_COEF_2] = BW_B1;
      coef_plan[CSR_NUM_COEF_3] = BW_B0;
      coef_plan[CSR_DEN_COEF_1] = BW_A1;
      coef_plan[CSR_DEN_COEF_2] = BW_A2;
      coef_plan[CSR_DEN_COEF_3] = BW_A3;
   endtask

   // Random coefficient set: low-pass, small gains, full range or corners
   task automatic plan_random();
      int mode;
      mode = $urandom_range(0, 3);
      case (mode)
         0: plan_lowpass();
         1: for (int i = 0; i < NUM_REGS; i++)
               coef_plan[i] = COEF_W'(int'($urandom_range(0, 524288)) - 262144);
         2: for (int i = 0; i < NUM_REGS; i++)
               coef_plan[i] = COEF_W'($urandom);
         default: for (int i = 0; i < NUM_REGS; i++)
               case ($urandom_range(0, 2))
                  0: coef_plan[i] = COEF_MAX;
                  1: coef_plan[i] = COEF_MIN;
                  default: coef_plan[i] = '0;
               endcase
      endcase
   endtask

   function automatic logic signed [SAMP_W-1:0] pick_sample();
      case ($urandom_range(0, 19))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return -16'sd1;
         default: return SAMP_W'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- receiver, checker, watchdog

   // Random ready, with an occasional long hold-off requested by a test
   always @(posedge clock) begin
      if (holdoff_count != holdoff_seen) begin
         holdoff_seen <= holdoff_count;
         hold_left    <= holdoff_len;
         rsp_ready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < MAX_PRINTED)
         $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      error_count++;
   endtask

   // Compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      filter_result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            report_mismatch("result with no item outstanding, filtered_out",
                            rsp_filtered_out, 0);
         end else begin
            e = expected_q.pop_front();
            if (rsp_filtered_out !== e.filtered)
               report_mismatch("filtered_out", rsp_filtered_out, $signed(e.filtered));
            if (rsp_saturated !== e.saturated)
               report_mismatch("saturated", rsp_saturated, e.saturated);
            results_checked++;
         end
      end
   end

   // End the run when no channel has moved for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                  idle_cycles, expected_q.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // Pass-through defaults straight out of reset
   task automatic test_reset_defaults();
      send_item(OP_FILTER, SAMPLE_MAX);
      send_item(OP_FILTER, SAMPLE_MIN);
      send_item(OP_FILTER, '0);
      send_item(OP_FILTER, 16'sd1);
      send_item(OP_FILTER, -16'sd1);
      send_item(OP_FILTER, 16'sh5555);
      drain();
   endtask

   // Flush returns zero and ignores its sample
   task automatic test_flush();
      send_item(OP_FLUSH, SAMPLE_MAX);
      drain();
   endtask

   // Half-way cases round toward plus infinity
   task automatic test_rounding();
      plan_passthrough();
      coef_plan[CSR_NUM_COEF_0] = COEF_HALF;
      load_coef_plan();
      send_item(OP_FILTER, 16'sd1);
      send_item(OP_FILTER, -16'sd1);
      send_item(OP_FILTER, 16'sd3);
      send_item(OP_FILTER, -16'sd3);
      drain();
   endtask

   // Clip both ways with every coefficient at an extreme
   task automatic test_saturation();
      plan_uniform(COEF_MAX);
      load_coef_plan();
      send_item(OP_FLUSH, '0);
      send_item(OP_FILTER, SAMPLE_MAX);
      send_item(OP_FILTER, SAMPLE_MIN);
      plan_uniform(COEF_MIN);
      load_coef_plan();
      send_item(OP_FLUSH, SAMPLE_MIN);
      send_item(OP_FILTER, SAMPLE_MAX);
      send_item(OP_FILTER, SAMPLE_MIN);
      drain();
   endtask

   // Impulse through the low-pass to exercise the first two feedback taps
   task automatic test_lowpass_impulse();
      plan_lowpass();
      load_coef_plan();
      send_item(OP_FLUSH, '0);
      send_item(OP_FILTER, SAMPLE_MAX);
      send_item(OP_FILTER, '0);
      send_item(OP_FILTER, '0);
      drain();
   endtask

   // A write past the last register must change nothing
   task automatic test_unused_index();
      plan_passthrough();
      load_coef_plan();
      @(posedge clock);
      write_coef(CSR_UNUSED_IDX, COEF_MAX);
      csr_valid <= 1'b0;
      send_item(OP_FILTER, 16'sd1234);
      send_item(OP_FILTER, SAMPLE_MIN);
      send_item(OP_FILTER, SAMPLE_MAX);
      drain();
   endtask

   // Mostly samples, some flushes, a fresh coefficient set every segment
   task automatic test_random_traffic(input int n_items, input int snd_pct, input int rcv_pct);
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      for (int n = 0; n < n_items; n++) begin
         if (n % SEGMENT_ITEMS == 0) begin
            plan_random();
            load_coef_plan();
         end
         if ($urandom_range(0, 99) < 8)
            send_item(OP_FLUSH, SAMP_W'($urandom));
         else
            send_item(OP_FILTER, pick_sample());
      end
      drain();
   endtask

   // Hold the receiver off while the sender keeps offering, so the input stalls
   task automatic test_output_holdoff();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      plan_lowpass();
      load_coef_plan();
      holdoff_len   <= HOLDOFF_CYCLES;
      holdoff_count <= holdoff_count + 1;
      for (int n = 0; n < 30; n++)
         send_item(OP_FILTER, pick_sample());
      drain();
   endtask

   // Sender pauses mid-stream until every result is back
   task automatic test_sender_pause();
      send_idle_pct = 18;
      recv_idle_pct = 50;
      for (int n = 0; n < 15; n++)
         send_item(OP_FILTER, pick_sample());
      drain();
      for (int n = 0; n < 15; n++)
         send_item(($urandom_range(0, 9) == 0) ? OP_FLUSH : OP_FILTER, pick_sample());
      drain();
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset_model();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 18;
      recv_idle_pct = 73;
      test_reset_defaults();
      test_flush();
      test_rounding();
      test_saturation();
      test_lowpass_impulse();
      test_unused_index();

      test_random_traffic(400, 18, 73);
      test_random_traffic(400, 73, 18);
      test_random_traffic(400, 0, 0);
      test_output_holdoff();
      test_sender_pause();

      drain();
      if (expected_q.size() != 0)
         report_mismatch("results never returned", expected_q.size(), 0);

      $display("Sent %0d items (%0d flushes), checked %0d results,",
               items_sent, flushes_sent, results_checked);
      $display("%0d register writes in %0d sets; covered rounding, clipping, flush,",
               csr_writes, coef_sets);
      $display("dropped index, three idle mixes and back-pressure.");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
